@@ sv/blpw_pkg.sv @@
// Shared types, widths and defaults for the line pixel walker.
package blpw_pkg;

   localparam int ADDR_W = 24;
   localparam int COL_W = 10;
   localparam int ROW_W = 9;
   localparam int LEN_W = 10;
   localparam int ERR_W = 11;
   localparam int LEFT_W = 11;
   localparam int MASK_W = 8;

   localparam int DEFAULT_SCREEN_COLS = 640;
   localparam int DEFAULT_SCREEN_ROWS = 400;
   localparam int DEFAULT_ROW_BYTES = 80;

   typedef enum logic {
      OP_START = 1'b0,
      OP_STEP  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STEP_NONE  = 2'b00,
      STEP_PLUS  = 2'b01,
      STEP_MINUS = 2'b11
   } step_code_type;

   typedef struct packed {
      step_code_type row;
      step_code_type col;
   } step_signs_type;

   typedef struct packed {
      logic              on_screen;
      logic [ADDR_W-1:0] address;
      logic [MASK_W-1:0] mask;
   } pixel_type;

endpackage

@@ sv/bresenham_line_pixel_walker_unit.sv @@
// Top level of the Bresenham line pixel walker for a 1-bit-per-pixel frame buffer.
//
// The req_ channel carries one item per command. A start item (op 0) latches the
// frame base and both endpoints and returns a result with only busy_res set. Each
// step item (op 1) returns the next pixel of the line from first to last point:
// byte address, MSB-first bit mask, write enable (clear when off screen) and a
// last flag. A step item while no line is active returns a result of all zeros.
// A start item during a line drops the old line.
//
// Every accepted item gives exactly one result on the rsp_ channel in the next
// cycle, from a single output register. The walker state is updated in the same
// cycle an item is accepted, so one item is taken every cycle while req_stall is
// low; the path between registers is the row multiply and 24-bit address add,
// and the error term add, compare and subtract.
//
// When the receiver stalls, the held result stays and req_stall rises only while
// the output register is full and stalled. Reset (synchronous) leaves the walker
// idle with no result pending.
module bresenham_line_pixel_walker_unit #(
   parameter int SCREEN_COLS = blpw_pkg::DEFAULT_SCREEN_COLS,
   parameter int SCREEN_ROWS = blpw_pkg::DEFAULT_SCREEN_ROWS,
   parameter int ROW_BYTES = blpw_pkg::DEFAULT_ROW_BYTES
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_op,
   input  logic [blpw_pkg::ADDR_W-1:0]  req_frame_base,
   input  logic [blpw_pkg::COL_W-1:0]   req_start_x,
   input  logic [blpw_pkg::ROW_W-1:0]   req_start_y,
   input  logic [blpw_pkg::COL_W-1:0]   req_end_x,
   input  logic [blpw_pkg::ROW_W-1:0]   req_end_y,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_write_pixel,
   output logic [blpw_pkg::ADDR_W-1:0]  rsp_pixel_address,
   output logic [blpw_pkg::MASK_W-1:0]  rsp_bit_mask,
   output logic                         rsp_last_pixel,
   output logic                         rsp_busy_res
);
   import blpw_pkg::*;

   logic [COL_W-1:0]  cur_col_ff, cur_col_in;
   logic [ROW_W-1:0]  cur_row_ff, cur_row_in;
   logic [ERR_W-1:0]  error_acc_ff, error_acc_in;
   logic [LEN_W-1:0]  major_len_ff, major_len_in;
   logic [LEN_W-1:0]  minor_len_ff, minor_len_in;
   step_signs_type    diag_signs_ff, diag_signs_in;
   step_signs_type    straight_signs_ff, straight_signs_in;
   logic [LEFT_W-1:0] pixels_left_ff, pixels_left_in;
   logic              line_active_ff, line_active_in;
   logic [ADDR_W-1:0] base_hold_ff, base_hold_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              write_pixel_ff, write_pixel_in;
   logic [ADDR_W-1:0] pixel_address_ff, pixel_address_in;
   logic [MASK_W-1:0] bit_mask_ff, bit_mask_in;
   logic              last_pixel_ff, last_pixel_in;
   logic              busy_res_ff, busy_res_in;

   logic              req_accept;
   logic              is_last;
   pixel_type         pixel;
   logic [COL_W-1:0]  abs_dx;
   logic [ROW_W-1:0]  abs_dy;
   step_code_type     sign_x;
   step_code_type     sign_y;
   logic [ERR_W-1:0]  err_sum;
   logic              take_diag;
   step_signs_type    step;

   function automatic step_code_type sign_of(input logic lt, input logic gt);
      step_code_type code;
      code = STEP_NONE;
      if (gt) begin
         code = STEP_PLUS;
      end else if (lt) begin
         code = STEP_MINUS;
      end
      return code;
   endfunction

   blpw_pixel_addr #(
      .SCREEN_COLS(SCREEN_COLS),
      .SCREEN_ROWS(SCREEN_ROWS),
      .ROW_BYTES(ROW_BYTES)
   ) u_pixel_addr (
      .base(base_hold_ff),
      .col(cur_col_ff),
      .row(cur_row_ff),
      .pixel(pixel)
   );

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign is_last = (pixels_left_ff <= LEFT_W'(1));

   assign abs_dx = (req_end_x >= req_start_x) ? req_end_x - req_start_x
                                              : req_start_x - req_end_x;
   assign abs_dy = (req_end_y >= req_start_y) ? req_end_y - req_start_y
                                              : req_start_y - req_end_y;
   assign sign_x = sign_of(req_end_x < req_start_x, req_end_x > req_start_x);
   assign sign_y = sign_of(req_end_y < req_start_y, req_end_y > req_start_y);

   assign err_sum = error_acc_ff + ERR_W'(minor_len_ff);
   assign take_diag = (err_sum >= ERR_W'(major_len_ff));
   assign step = take_diag ? diag_signs_ff : straight_signs_ff;

   always_comb begin
      cur_col_in = cur_col_ff;
      cur_row_in = cur_row_ff;
      error_acc_in = error_acc_ff;
      major_len_in = major_len_ff;
      minor_len_in = minor_len_ff;
      diag_signs_in = diag_signs_ff;
      straight_signs_in = straight_signs_ff;
      pixels_left_in = pixels_left_ff;
      line_active_in = line_active_ff;
      base_hold_in = base_hold_ff;

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      write_pixel_in = write_pixel_ff;
      pixel_address_in = pixel_address_ff;
      bit_mask_in = bit_mask_ff;
      last_pixel_in = last_pixel_ff;
      busy_res_in = busy_res_ff;

      if (req_accept) begin
         rsp_valid_in = 1'b1;
         write_pixel_in = 1'b0;
         pixel_address_in = '0;
         bit_mask_in = '0;
         last_pixel_in = 1'b0;
         busy_res_in = 1'b0;

         if (req_op == OP_START) begin
            base_hold_in = req_frame_base;
            cur_col_in = req_start_x;
            cur_row_in = req_start_y;
            diag_signs_in = '{row: sign_y, col: sign_x};
            if (LEN_W'(abs_dx) > LEN_W'(abs_dy)) begin
               major_len_in = LEN_W'(abs_dx);
               minor_len_in = LEN_W'(abs_dy);
               straight_signs_in = '{row: STEP_NONE, col: sign_x};
            end else begin
               major_len_in = LEN_W'(abs_dy);
               minor_len_in = LEN_W'(abs_dx);
               straight_signs_in = '{row: sign_y, col: STEP_NONE};
            end
            error_acc_in = ERR_W'(major_len_in >> 1);
            pixels_left_in = LEFT_W'(major_len_in) + LEFT_W'(1);
            line_active_in = 1'b1;
            busy_res_in = 1'b1;
         end else if (line_active_ff) begin
            write_pixel_in = pixel.on_screen;
            pixel_address_in = pixel.address;
            bit_mask_in = pixel.mask;
            last_pixel_in = is_last;
            busy_res_in = !is_last;

            error_acc_in = take_diag ? err_sum - ERR_W'(major_len_ff) : err_sum;

            case (step.col)
               STEP_PLUS: cur_col_in = cur_col_ff + COL_W'(1);
               STEP_MINUS: cur_col_in = cur_col_ff - COL_W'(1);
               default: cur_col_in = cur_col_ff;
            endcase
            case (step.row)
               STEP_PLUS: cur_row_in = cur_row_ff + ROW_W'(1);
               STEP_MINUS: cur_row_in = cur_row_ff - ROW_W'(1);
               default: cur_row_in = cur_row_ff;
            endcase

            if (is_last) begin
               pixels_left_in = '0;
               line_active_in = 1'b0;
            end else begin
               pixels_left_in = pixels_left_ff - LEFT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_col_ff <= '0;
         cur_row_ff <= '0;
         error_acc_ff <= '0;
         major_len_ff <= '0;
         minor_len_ff <= '0;
         diag_signs_ff <= '{row: STEP_NONE, col: STEP_NONE};
         straight_signs_ff <= '{row: STEP_NONE, col: STEP_NONE};
         pixels_left_ff <= '0;
         line_active_ff <= 1'b0;
         base_hold_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_col_ff <= cur_col_in;
         cur_row_ff <= cur_row_in;
         error_acc_ff <= error_acc_in;
         major_len_ff <= major_len_in;
         minor_len_ff <= minor_len_in;
         diag_signs_ff <= diag_signs_in;
         straight_signs_ff <= straight_signs_in;
         pixels_left_ff <= pixels_left_in;
         line_active_ff <= line_active_in;
         base_hold_ff <= base_hold_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      write_pixel_ff <= write_pixel_in;
      pixel_address_ff <= pixel_address_in;
      bit_mask_ff <= bit_mask_in;
      last_pixel_ff <= last_pixel_in;
      busy_res_ff <= busy_res_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_write_pixel = write_pixel_ff;
   assign rsp_pixel_address = pixel_address_ff;
   assign rsp_bit_mask = bit_mask_ff;
   assign rsp_last_pixel = last_pixel_ff;
   assign rsp_busy_res = busy_res_ff;

   a_start_opens_line: assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_op == OP_START) |=> line_active_ff && rsp_valid && rsp_busy_res)
      else $error("start item did not open a line");

   a_last_closes_line: assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_op == OP_STEP) && line_active_ff && is_last
      |=> !line_active_ff && rsp_last_pixel && !rsp_busy_res)
      else $error("final pixel did not close the line");

   a_write_has_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_write_pixel |-> $onehot(rsp_bit_mask))
      else $error("pixel write without a one-hot mask");

   a_active_has_pixels: assert property (@(posedge clock) disable iff (reset)
      line_active_ff |-> (pixels_left_ff != '0))
      else $error("active line with no pixels left");

endmodule

@@ sv/blpw_pixel_addr.sv @@
// Frame buffer byte address, bit mask and screen clip for one pixel position.
module blpw_pixel_addr #(
   parameter int SCREEN_COLS = blpw_pkg::DEFAULT_SCREEN_COLS,
   parameter int SCREEN_ROWS = blpw_pkg::DEFAULT_SCREEN_ROWS,
   parameter int ROW_BYTES = blpw_pkg::DEFAULT_ROW_BYTES
) (
   input  logic [blpw_pkg::ADDR_W-1:0] base,
   input  logic [blpw_pkg::COL_W-1:0]  col,
   input  logic [blpw_pkg::ROW_W-1:0]  row,
   output blpw_pkg::pixel_type         pixel
);
   import blpw_pkg::*;

   localparam int RB_W = $clog2(ROW_BYTES + 1);
   localparam int PROD_W = ROW_W + RB_W;

   logic [PROD_W-1:0] row_offset;

   assign row_offset = PROD_W'(row) * PROD_W'(ROW_BYTES);

   always_comb begin
      pixel.address = base + ADDR_W'(row_offset) + ADDR_W'(col[COL_W-1:3]);
      pixel.mask = 8'h80 >> col[2:0];
      pixel.on_screen = ({1'b0, col} < (COL_W + 1)'(SCREEN_COLS))
                        && ({1'b0, row} < (ROW_W + 1)'(SCREEN_ROWS));
   end

endmodule
